### rtl/core/lrpt_pkg.sv
// Package for the loop region playback timer.
// Command codes, configuration register indexes, sequencer states, port widths.
// No dependencies.
package lrpt_pkg;

  localparam int PORT_TIME_W = 32;
  localparam int WEIGHT_W    = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 3;

  localparam int DEF_TIME_BITS        = 32;
  localparam int DEF_WEIGHT_FRAC_BITS = 15;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_DURATION = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } lrpt_state_t;

endpackage

### rtl/core/lrpt_if.sv
// Request channels of the loop region playback timer: command in, result out.
// Depends on lrpt_pkg.
interface lrpt_cmd_if;
  import lrpt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [PORT_TIME_W-1:0] elapsed;
  modport source (output valid, output kind, output elapsed, input ready);
  modport sink (input valid, input kind, input elapsed, output ready);
endinterface

interface lrpt_res_if;
  import lrpt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PORT_TIME_W-1:0] position;
  logic [WEIGHT_W-1:0]    fade_weight;
  logic                   fading;
  logic                   at_end;
  logic                   running;
  modport source (output valid, output position, output fade_weight, output fading,
                  output at_end, output running, input ready);
  modport sink (input valid, input position, input fade_weight, input fading,
                input at_end, input running, output ready);
endinterface

### rtl/core/loop_region_playback_timer.sv
// Loop region playback timer: position counter with loop wrap and fade-in weight.
// Depends on lrpt_pkg and the channel interfaces in lrpt_if.sv.
//
//   channel  dir  payload                                         handshake
//   cmd      in   kind, elapsed                                   valid/ready
//   res      out  position, fade_weight, fading, at_end, running  valid/ready
//   cfg      in   cfg_index, cfg_data                             cfg_we only
//
// A tick on a running clip passes through the calc, divide and finish steps, where
// the bit-serial restoring divider works out the modulo of the loop region, with the
// weight fraction alongside. Play, stop, unused codes and idle ticks go straight to the done step.
// Reset clears configuration and playback state at once; no clearing pass.
// A new request is taken while the previous result waits in the output register;
// a result stalls in the last step until that register is free.
module loop_region_playback_timer #(
  parameter int TIME_BITS        = lrpt_pkg::DEF_TIME_BITS,
  parameter int WEIGHT_FRAC_BITS = lrpt_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  lrpt_cmd_if.sink                         cmd,
  lrpt_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [lrpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrpt_pkg::PORT_TIME_W-1:0] cfg_data
);
  import lrpt_pkg::*;

  localparam int T    = TIME_BITS;
  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int CntW = $clog2(T);
  localparam logic [WEIGHT_W-1:0] WeightFull =
    (F >= WEIGHT_W) ? {WEIGHT_W{1'b1}} : WEIGHT_W'(1 << F);

  // configuration
  logic [T-1:0] clip_length, skip_start, early_end, fade_duration;
  logic         loop_enable;

  // playback state
  logic         active, looping, fade_armed;
  logic [T-1:0] play_pos, fade_count;
  logic [WEIGHT_W-1:0] weight_reg;

  // sequencer and serial divider
  lrpt_state_t  state, state_next;
  logic [T-1:0] end_q, len_q, dividend, rem, frac_rem;
  logic [F-1:0] quot;
  logic         mod_busy, frac_busy;
  logic [CntW-1:0] cnt;
  logic         out_valid, out_load, div_last;

  logic [T-1:0] el;
  logic [T:0]   pos_sum, fc_sum, fin_sum, mod_try, frac_try;
  logic [T-1:0] pos_sat, fc_sat, fin_sat, region_end, mod_next, frac_next;
  logic [F-1:0] quot_next;
  logic         frac_step;

  assign el         = cmd.elapsed[T-1:0];
  assign pos_sum    = {1'b0, play_pos} + {1'b0, el};
  assign pos_sat    = pos_sum[T] ? {T{1'b1}} : pos_sum[T-1:0];
  assign fc_sum     = {1'b0, fade_count} + {1'b0, el};
  assign fc_sat     = fc_sum[T] ? {T{1'b1}} : fc_sum[T-1:0];
  assign fin_sum    = {1'b0, rem} + {1'b0, skip_start};
  assign fin_sat    = fin_sum[T] ? {T{1'b1}} : fin_sum[T-1:0];
  assign region_end = (clip_length >= early_end) ? clip_length - early_end : '0;

  // one remainder bit per cycle
  assign mod_try   = {rem, dividend[T-1]};
  assign mod_next  = (mod_try >= {1'b0, len_q}) ? T'(mod_try - {1'b0, len_q})
                                                : mod_try[T-1:0];
  assign frac_try  = {frac_rem, 1'b0};
  assign frac_next = (frac_try >= {1'b0, fade_duration})
                     ? T'(frac_try - {1'b0, fade_duration}) : frac_try[T-1:0];
  assign quot_next = {quot[F-2:0], (frac_try >= {1'b0, fade_duration})};
  assign frac_step = frac_busy && ({1'b0, cnt} < (CntW+1)'(F));
  assign div_last  = (cnt == CntW'(T-1));

  always_comb begin
    cmd.ready = (state == ST_IDLE);
    out_load  = (state == ST_DONE) && (!out_valid || res.ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.kind == KIND_TICK && active) ? ST_CALC : ST_DONE;
        end
      end
      ST_CALC: state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_FIN;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_length   <= '0;
      skip_start    <= '0;
      early_end     <= '0;
      loop_enable   <= 1'b0;
      fade_duration <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_LENGTH:   clip_length   <= cfg_data[T-1:0];
        CFG_SKIP_START:    skip_start    <= cfg_data[T-1:0];
        CFG_EARLY_END:     early_end     <= cfg_data[T-1:0];
        CFG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        CFG_FADE_DURATION: fade_duration <= cfg_data[T-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      looping    <= 1'b0;
      fade_armed <= 1'b0;
      play_pos   <= '0;
      fade_count <= '0;
      weight_reg <= '0;
      mod_busy   <= 1'b0;
      frac_busy  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            end_q <= region_end;
            if (cmd.kind == KIND_TICK) begin
              if (active) begin
                play_pos <= pos_sat;
                if (fade_armed) fade_count <= fc_sat;
              end
            end else if (cmd.kind == KIND_PLAY) begin
              active     <= 1'b1;
              looping    <= loop_enable;
              play_pos   <= skip_start;
              fade_armed <= (fade_duration != '0);
              fade_count <= '0;
              weight_reg <= '0;
            end else if (cmd.kind == KIND_STOP) begin
              looping  <= 1'b0;
              play_pos <= region_end;
            end
          end
        end
        ST_CALC: begin
          cnt      <= '0;
          rem      <= '0;
          dividend <= play_pos;
          len_q    <= end_q - skip_start;
          if (play_pos >= end_q) begin
            if (!looping) begin
              play_pos <= end_q;
            end else if (end_q <= skip_start) begin
              play_pos <= skip_start;
            end else begin
              mod_busy <= 1'b1;
            end
          end
          frac_rem <= fade_count;
          quot     <= '0;
          if (fade_armed) begin
            if (fade_count >= fade_duration) begin
              fade_count <= fade_duration;
              fade_armed <= 1'b0;
              weight_reg <= WeightFull;
            end else begin
              frac_busy <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (mod_busy) begin
            rem      <= mod_next;
            dividend <= {dividend[T-2:0], 1'b0};
          end
          if (frac_step) begin
            frac_rem <= frac_next;
            quot     <= quot_next;
            if ({1'b0, cnt} == (CntW+1)'(F-1)) begin
              frac_busy  <= 1'b0;
              weight_reg <= WEIGHT_W'(quot_next);
            end
          end
        end
        ST_FIN: begin
          if (mod_busy) begin
            play_pos <= fin_sat;
            mod_busy <= 1'b0;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.position    <= PORT_TIME_W'(play_pos);
      res.fade_weight <= weight_reg;
      res.fading      <= fade_armed;
      res.at_end      <= active && !looping && (play_pos == end_q);
      res.running     <= active;
    end
  end

  assign res.valid = out_valid;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> state != ST_IDLE)
    else $error("request taken but sequencer stayed idle");

  a_idle_no_fade: assert property (@(posedge clk) disable iff (rst)
    !active |-> !fade_armed && fade_count == '0 && weight_reg == '0)
    else $error("fade state moved before play");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && mod_busy |-> rem < len_q)
    else $error("loop remainder out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == ST_IDLE)
    else $error("result not presented after completion");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for loop_region_playback_timer: directed and random play, stop, tick and
// unused requests, each result checked against an in-bench playback and fade predictor.
// Depends on lrpt_pkg and the channel interfaces in lrpt_if.sv.
module tb;
  import lrpt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << DEF_WEIGHT_FRAC_BITS);
  localparam logic [PORT_TIME_W-1:0] TIME_MAX = '1;
  localparam int TAIL_CYCLES = DEF_TIME_BITS + 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [PORT_TIME_W-1:0] position;
    logic [WEIGHT_W-1:0]    fade_weight;
    logic                   fading;
    logic                   at_end;
    logic                   running;
  } status_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [PORT_TIME_W-1:0] cfg_data;

  lrpt_cmd_if cmd_ch ();
  lrpt_res_if res_ch ();

  loop_region_playback_timer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of configuration and playback state
  logic [PORT_TIME_W-1:0] clip_len, skip_pt, early_cut, fade_len;
  logic                   loop_on;
  logic                   playing, wrap_on, fade_on;
  logic [PORT_TIME_W-1:0] play_time, fade_time;
  logic [WEIGHT_W-1:0]    weight_q;

  status_t status_q[$];
  int      failures = 0;
  int      idle_cycles = 0;
  bit      steady = 1'b0;

  function automatic logic [PORT_TIME_W-1:0] sat_sum(input logic [PORT_TIME_W-1:0] a,
                                                     input logic [PORT_TIME_W-1:0] b);
    logic [PORT_TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PORT_TIME_W] ? TIME_MAX : s[PORT_TIME_W-1:0];
  endfunction

  function automatic logic [PORT_TIME_W-1:0] region_end();
    return (clip_len >= early_cut) ? clip_len - early_cut : '0;
  endfunction

  function automatic status_t predict_playback(input logic [KIND_W-1:0] kind,
                                               input logic [PORT_TIME_W-1:0] elapsed);
    logic [PORT_TIME_W-1:0] stop_pt, span;
    logic [PORT_TIME_W+WEIGHT_W-1:0] scaled;
    status_t r;
    stop_pt = region_end();
    case (kind)
      KIND_TICK: begin
        if (playing) begin
          play_time = sat_sum(play_time, elapsed);
          if (play_time >= stop_pt) begin
            if (wrap_on) begin
              span = (stop_pt > skip_pt) ? stop_pt - skip_pt : '0;
              play_time = (span == 0) ? skip_pt : sat_sum(play_time % span, skip_pt);
            end else begin
              play_time = stop_pt;
            end
          end
          if (fade_on) begin
            fade_time = sat_sum(fade_time, elapsed);
            if (fade_time >= fade_len) begin
              fade_time = fade_len;
              fade_on   = 1'b0;
              weight_q  = WEIGHT_ONE;
            end else begin
              scaled   = {fade_time, {DEF_WEIGHT_FRAC_BITS{1'b0}}} / fade_len;
              weight_q = (scaled > 'hFFFF) ? '1 : scaled[WEIGHT_W-1:0];
            end
          end
        end
      end
      KIND_PLAY: begin
        playing   = 1'b1;
        wrap_on   = loop_on;
        play_time = skip_pt;
        fade_on   = (fade_len != 0);
        fade_time = '0;
        weight_q  = '0;
      end
      KIND_STOP: begin
        wrap_on   = 1'b0;
        play_time = stop_pt;
      end
      default: ;
    endcase
    r.position    = play_time;
    r.fade_weight = weight_q;
    r.fading      = fade_on;
    r.at_end      = playing && !wrap_on && (play_time == stop_pt);
    r.running     = playing;
    return r;
  endfunction

  function automatic logic [PORT_TIME_W-1:0] rand_span(input logic [PORT_TIME_W-1:0] hint);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return TIME_MAX;
      2: return $urandom;
      default: return $urandom_range(0, hint);
    endcase
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [PORT_TIME_W-1:0] elapsed);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.kind    <= kind;
    cmd_ch.elapsed <= elapsed;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    status_q.insert(status_q.size(), predict_playback(kind, elapsed));
  endtask

  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // only called once the block is idle
  task automatic configure(input logic [PORT_TIME_W-1:0] clip, input logic [PORT_TIME_W-1:0] skip,
                           input logic [PORT_TIME_W-1:0] early, input logic loop,
                           input logic [PORT_TIME_W-1:0] fade);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CLIP_LENGTH;   cfg_data <= clip;  @(posedge clk);
    cfg_index <= CFG_SKIP_START;    cfg_data <= skip;  @(posedge clk);
    cfg_index <= CFG_EARLY_END;     cfg_data <= early; @(posedge clk);
    cfg_index <= CFG_LOOP_ENABLE;   cfg_data <= {{(PORT_TIME_W-1){1'b0}}, loop}; @(posedge clk);
    cfg_index <= CFG_FADE_DURATION; cfg_data <= fade;  @(posedge clk);
    cfg_we <= 1'b0;
    clip_len  = clip;
    skip_pt   = skip;
    early_cut = early;
    loop_on   = loop;
    fade_len  = fade;
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (status_q.size() == 0) begin
        $error("unexpected result: position %0d", res_ch.position);
        failures++;
      end else begin
        want = status_q.pop_front();
        if (res_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, res_ch.position);
          failures++;
        end
        if (res_ch.fade_weight !== want.fade_weight) begin
          $error("fade_weight: expected %0d, got %0d", want.fade_weight, res_ch.fade_weight);
          failures++;
        end
        if (res_ch.fading !== want.fading) begin
          $error("fading: expected %0b, got %0b", want.fading, res_ch.fading);
          failures++;
        end
        if (res_ch.at_end !== want.at_end) begin
          $error("at_end: expected %0b, got %0b", want.at_end, res_ch.at_end);
          failures++;
        end
        if (res_ch.running !== want.running) begin
          $error("running: expected %0b, got %0b", want.running, res_ch.running);
          failures++;
        end
      end
    end
  end

  initial begin : result_stalls
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_idle_commands();
    send_request(KIND_TICK, TIME_MAX);
    send_request(KIND_STOP, 32'd17);
    send_request(KIND_UNUSED, TIME_MAX);
    send_request(KIND_TICK, '0);
    wait_for_results();
  endtask

  task automatic test_loop_and_fade();
    configure(32'd1000, 32'd100, 32'd200, 1'b1, 32'd50);
    send_request(KIND_PLAY, '0);
    send_request(KIND_TICK, 32'd30);
    send_request(KIND_TICK, 32'd30);
    send_request(KIND_TICK, 32'd900);
    send_request(KIND_STOP, '0);
    send_request(KIND_TICK, 32'd5);
    wait_for_results();
  endtask

  task automatic test_clamp_and_empty_region();
    configure(32'd1000, '0, '0, 1'b0, '0);
    send_request(KIND_PLAY, TIME_MAX);
    send_request(KIND_TICK, 32'd2000);
    wait_for_results();
    // loop region collapses onto the skip point
    configure(32'd100, 32'd100, '0, 1'b1, '0);
    send_request(KIND_PLAY, '0);
    send_request(KIND_TICK, 32'd5);
    wait_for_results();
    // early end beyond the clip length
    configure(32'd10, '0, 32'd20, 1'b1, '0);
    send_request(KIND_PLAY, '0);
    send_request(KIND_TICK, 32'd1);
    wait_for_results();
  endtask

  task automatic test_saturation();
    configure(TIME_MAX, TIME_MAX - 32'd10, '0, 1'b1, TIME_MAX);
    send_request(KIND_PLAY, '0);
    send_request(KIND_TICK, TIME_MAX);
    send_request(KIND_UNUSED, '0);
    wait_for_results();
  endtask

  task automatic test_fade_change();
    configure(32'd1000, '0, '0, 1'b0, 32'd1000);
    send_request(KIND_PLAY, '0);
    send_request(KIND_TICK, 32'd10);
    wait_for_results();
    configure(32'd1000, '0, '0, 1'b0, '0);
    send_request(KIND_TICK, 32'd10);
    wait_for_results();
  endtask

  task automatic test_random_playback();
    logic [PORT_TIME_W-1:0] clip, skip, early, hint;
    logic [KIND_W-1:0] kind;
    int pick;
    for (int phase = 0; phase < 16; phase++) begin
      steady = ($urandom_range(0, 3) == 0);
      clip  = rand_span(32'd3000);
      skip  = ($urandom_range(0, 4) == 0) ? rand_span(32'd3000) : $urandom_range(0, clip / 3);
      early = ($urandom_range(0, 4) == 0) ? rand_span(32'd3000) : $urandom_range(0, clip / 3);
      configure(clip, skip, early, $urandom_range(0, 2) != 0, rand_span(32'd500));
      hint = (clip < 32'd4000) ? clip / 4 + 1 : 32'd1000;
      for (int n = 0; n < 50; n++) begin
        if (n == 25 && phase[0]) begin
          wait_for_results();
          configure(clip_len, skip_pt, early_cut, loop_on, rand_span(32'd500));
        end
        pick = $urandom_range(0, 99);
        if (n == 0)        kind = KIND_PLAY;
        else if (pick < 78) kind = KIND_TICK;
        else if (pick < 87) kind = KIND_PLAY;
        else if (pick < 96) kind = KIND_STOP;
        else               kind = KIND_UNUSED;
        send_request(kind, rand_span(hint));
      end
      wait_for_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_CLIP_LENGTH;
    cfg_data       <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.kind    <= KIND_TICK;
    cmd_ch.elapsed <= '0;
    clip_len  = '0;
    skip_pt   = '0;
    early_cut = '0;
    loop_on   = 1'b0;
    fade_len  = '0;
    playing   = 1'b0;
    wrap_on   = 1'b0;
    fade_on   = 1'b0;
    play_time = '0;
    fade_time = '0;
    weight_q  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_commands();
    test_loop_and_fade();
    test_clamp_and_empty_region();
    test_saturation();
    test_fade_change();
    test_random_playback();

    wait_for_results();
    if (failures == 0 && status_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
